### design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the bit rate meter RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge, muted while reset is asserted.
`define BRM_ASSERT(label, prop, clk, rst_n, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Checked on every clock edge, reset included.
`define BRM_ASSERT_ALWAYS(label, prop, clk, msg) \
  label: assert property (@(posedge clk) (prop)) \
    else $error(msg);

`endif

### design/brm_pkg.sv
// ----------------------------------------------------------------------------
// brm_pkg
// Types and constants shared by the bit rate meter modules.
// ----------------------------------------------------------------------------
package brm_pkg;

  localparam int unsigned CMD_W     = 2;
  localparam int unsigned NOW_W     = 32;
  localparam int unsigned BYTE_W    = 32;
  localparam int unsigned RATE_W    = 31;
  localparam int unsigned PERIOD_W  = 32;
  localparam int unsigned PREC_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 32;

  // byte_total * 16000 needs 46 bits, adding d (<= that product) needs 47
  localparam int unsigned NUM_W  = 46;
  localparam int unsigned NUMD_W = 47;

  localparam logic [NUM_W-1:0]    RATE_SCALE      = NUM_W'(16000);
  localparam logic [RATE_W-1:0]   RATE_MAX        = {RATE_W{1'b1}};
  localparam int unsigned         PRESET_BACKDATE = 2000;
  localparam logic [PERIOD_W-1:0] PERIOD_MIN      = PERIOD_W'(50);
  localparam logic [PERIOD_W-1:0] PERIOD_FALLBACK = PERIOD_W'(2000);
  localparam logic [PERIOD_W-1:0] PERIOD_RESET    = PERIOD_W'(4000);
  localparam logic [PREC_W-1:0]   PREC_ONE        = PREC_W'(1);

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD     = 2'd0,
    CMD_PRESET  = 2'd1,
    CMD_RESTART = 2'd2
  } brm_cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PERIOD    = 2'd0,
    CFG_AVERAGE   = 2'd1,
    CFG_PRECISION = 2'd2
  } brm_cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_APPLY,
    S_MOD_WAIT,
    S_CALC_T,
    S_CALC_D,
    S_CHECK,
    S_RATE_WAIT,
    S_COMMIT,
    S_OUT
  } brm_state_e;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [NOW_W-1:0]  now_ms;
    logic [BYTE_W-1:0] byte_count;
    logic              calc_enable;
    logic [RATE_W-1:0] preset_value;
  } in_item_t;

  typedef struct packed {
    logic [RATE_W-1:0] rate_bps;
    logic              updated;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load_item;
    logic apply;
    logic div_start;
    logic div_rate;   // 0: timestamp modulo, 1: rate quotient
    logic calc_t;
    logic calc_d;
    logic commit;
    logic out_load;
  } brm_ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic add_calc;
    logic prec_one;
    logic pass;
    logic zero_rate;
  } brm_stat_t;

endpackage

### design/brm_stream_if.sv
// ----------------------------------------------------------------------------
// brm_stream_if
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
interface brm_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### design/brm_divider.sv
// ----------------------------------------------------------------------------
// brm_divider
// Restoring radix-2 divider, one quotient bit per cycle, left-aligned operand.
// ----------------------------------------------------------------------------
module brm_divider import brm_pkg::*; #(
  parameter int unsigned Width = 47
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [$clog2(Width+1)-1:0]     steps_i,
  input  logic [Width-1:0]               dividend_i,
  input  logic [Width-1:0]               divisor_i,
  output logic                           busy_o,
  output logic                           done_o,
  output logic [Width-1:0]               quotient_o,
  output logic [Width-1:0]               remainder_o
);
  localparam int unsigned StepW = $clog2(Width+1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [StepW-1:0] cnt_q, cnt_d;
  logic [Width-1:0] quo_q, quo_d;   // dividend bits out at the top, quotient in at the bottom
  logic [Width-1:0] rem_q, rem_d;
  logic [Width-1:0] dvs_q, dvs_d;
  logic [Width:0]   shifted;
  logic [Width:0]   diff;
  logic             ge;

  always_comb begin
    shifted = {rem_q, quo_q[Width-1]};
    ge      = shifted >= {1'b0, dvs_q};
    diff    = shifted - {1'b0, dvs_q};
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = steps_i;
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d  = ge ? diff[Width-1:0] : shifted[Width-1:0];
      quo_d  = {quo_q[Width-2:0], ge};
      cnt_d  = cnt_q - StepW'(1);
      busy_d = (cnt_q != StepW'(1));
      done_d = (cnt_q == StepW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o      = busy_q;
  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

### design/brm_datapath.sv
// ----------------------------------------------------------------------------
// brm_datapath
// Configuration, meter state, item and intermediate registers, result register.
// ----------------------------------------------------------------------------
module brm_datapath import brm_pkg::*; #(
  parameter int unsigned TimeWidth = 32,
  parameter int unsigned DivW      = 47
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [CFG_W-1:0]             cfg_wdata_i,
  input  in_item_t                     item_i,
  input  brm_ctrl_t                    ctrl_i,
  output brm_stat_t                    stat_o,
  output logic [$clog2(DivW+1)-1:0]    div_steps_o,
  output logic [DivW-1:0]              div_dividend_o,
  output logic [DivW-1:0]              div_divisor_o,
  input  logic [DivW-1:0]              div_quotient_i,
  input  logic [DivW-1:0]              div_remainder_i,
  output out_item_t                    out_item_o
);
  localparam int unsigned StepW = $clog2(DivW+1);
  localparam int unsigned GapW  = TimeWidth + 3;
  localparam int unsigned PCmpW = (TimeWidth > PERIOD_W) ? TimeWidth : PERIOD_W;
  localparam int unsigned GCmpW = (GapW > PERIOD_W + 2) ? GapW : PERIOD_W + 2;
  localparam int unsigned NCmpW = (TimeWidth > NUM_W) ? TimeWidth : NUM_W;

  // configuration
  logic [PERIOD_W-1:0] period_q;
  logic                avg_q;
  logic [PREC_W-1:0]   prec_q;

  // meter state
  logic [TimeWidth-1:0] ws_q, ws_d;
  logic [TimeWidth-1:0] lut_q, lut_d;
  logic [BYTE_W-1:0]    bt_q, bt_d;
  logic [RATE_W-1:0]    rate_q, rate_d;
  logic                 upd_q;

  // captured item
  logic [CMD_W-1:0]     cmd_q;
  logic [TimeWidth-1:0] now_q;
  logic [BYTE_W-1:0]    bytes_q;
  logic                 calc_q;
  logic [RATE_W-1:0]    preset_q;

  // recompute intermediates
  logic [TimeWidth-1:0] t_q, t_d;
  logic [TimeWidth-1:0] d_q;
  logic [GapW-1:0]      gap5_q;   // 5*gap + 4, compared against 4*period
  logic [NUM_W-1:0]     num_q;
  logic [TimeWidth-1:0] gap;
  logic [GapW-1:0]      gap_ext;
  logic [NUMD_W-1:0]    numd;
  logic [NUMD_W-1:0]    dvs2;
  logic [RATE_W-1:0]    rate_sat;

  out_item_t out_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PERIOD_RESET;
      avg_q    <= 1'b1;
      prec_q   <= PREC_ONE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PERIOD: begin
          period_q <= (cfg_wdata_i < PERIOD_MIN) ? PERIOD_FALLBACK : cfg_wdata_i;
        end
        CFG_AVERAGE: begin
          avg_q <= cfg_wdata_i[0];
        end
        CFG_PRECISION: begin
          prec_q <= (cfg_wdata_i[PREC_W-1:0] == '0) ? PREC_ONE : cfg_wdata_i[PREC_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // captured item
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_item) begin
      cmd_q    <= item_i.cmd;
      now_q    <= TimeWidth'(item_i.now_ms);
      bytes_q  <= item_i.byte_count;
      calc_q   <= item_i.calc_enable;
      preset_q <= item_i.preset_value;
    end
  end

  // recompute arithmetic
  always_comb begin
    gap      = now_q - lut_q;
    gap_ext  = GapW'(gap);
    t_d      = (prec_q == PREC_ONE) ? now_q
                                    : now_q - TimeWidth'(div_remainder_i[PREC_W-1:0]);
    numd     = NUMD_W'(num_q) + NUMD_W'(d_q);
    dvs2     = NUMD_W'({d_q, 1'b0});
    rate_sat = (|div_quotient_i[DivW-1:RATE_W]) ? RATE_MAX : div_quotient_i[RATE_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.calc_t) begin
      t_q <= t_d;
    end
    if (ctrl_i.calc_d) begin
      d_q    <= t_q - ws_q;
      gap5_q <= (gap_ext << 2) + gap_ext + GapW'(4);
      num_q  <= NUM_W'(bt_q) * RATE_SCALE;
    end
  end

  // divider operands, dividends left-aligned in both modes so only the live bits are iterated
  always_comb begin
    if (ctrl_i.div_rate) begin
      div_steps_o    = StepW'(NUMD_W);
      div_dividend_o = DivW'(numd) << (DivW - NUMD_W);
      div_divisor_o  = DivW'(dvs2);
    end else begin
      div_steps_o    = StepW'(TimeWidth);
      div_dividend_o = DivW'(now_q) << (DivW - TimeWidth);
      div_divisor_o  = DivW'(prec_q);
    end
  end

  // meter state update
  always_comb begin
    ws_d   = ws_q;
    lut_d  = lut_q;
    bt_d   = bt_q;
    rate_d = rate_q;
    if (ctrl_i.apply) begin
      unique case (cmd_q)
        CMD_ADD: begin
          bt_d = bt_q + bytes_q;
        end
        CMD_PRESET: begin
          rate_d = preset_q;
          ws_d   = now_q - TimeWidth'(PRESET_BACKDATE);
          bt_d   = BYTE_W'(preset_q >> 2);
        end
        CMD_RESTART: begin
          ws_d   = now_q;
          lut_d  = now_q;
          bt_d   = '0;
          rate_d = '0;
        end
        default: begin
        end
      endcase
    end else if (ctrl_i.commit) begin
      lut_d  = now_q;
      rate_d = stat_o.zero_rate ? '0 : rate_sat;
      if (avg_q) begin
        ws_d = (ws_q >> 1) + (t_q >> 1);
        bt_d = bt_q >> 1;
      end else begin
        ws_d = t_q;
        bt_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q   <= '0;
      lut_q  <= '0;
      bt_q   <= '0;
      rate_q <= '0;
      upd_q  <= 1'b0;
    end else begin
      ws_q   <= ws_d;
      lut_q  <= lut_d;
      bt_q   <= bt_d;
      rate_q <= rate_d;
      if (ctrl_i.load_item) begin
        upd_q <= 1'b0;
      end else if (ctrl_i.commit) begin
        upd_q <= 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_load) begin
      out_q.rate_bps <= rate_q;
      out_q.updated  <= upd_q;
    end
  end

  assign out_item_o = out_q;

  always_comb begin
    stat_o.add_calc  = (cmd_q == CMD_ADD) && calc_q;
    stat_o.prec_one  = (prec_q == PREC_ONE);
    stat_o.pass      = (PCmpW'(d_q) >= PCmpW'(period_q)) &&
                       (GCmpW'(gap5_q) >= GCmpW'({period_q, 2'b00}));
    stat_o.zero_rate = NCmpW'(d_q) > NCmpW'(num_q);
  end

endmodule

### design/brm_ctrl.sv
// ----------------------------------------------------------------------------
// brm_ctrl
// Sequencer for one item: apply, optional recompute, result hand-off.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module brm_ctrl import brm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  brm_stat_t stat_i,
  input  logic      div_busy_i,
  input  logic      div_done_i,
  output brm_ctrl_t cmd_o
);
  brm_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = (state_q == S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd_o.apply = 1'b1;
        if (!stat_i.add_calc) begin
          state_d = S_OUT;
        end else if (stat_i.prec_one) begin
          state_d = S_CALC_T;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = S_MOD_WAIT;
        end
      end
      S_MOD_WAIT: begin
        if (div_done_i) begin
          state_d = S_CALC_T;
        end
      end
      S_CALC_T: begin
        cmd_o.calc_t = 1'b1;
        state_d      = S_CALC_D;
      end
      S_CALC_D: begin
        cmd_o.calc_d = 1'b1;
        state_d      = S_CHECK;
      end
      S_CHECK: begin
        if (!stat_i.pass) begin
          state_d = S_OUT;
        end else if (stat_i.zero_rate) begin
          state_d = S_COMMIT;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_rate  = 1'b1;
          state_d         = S_RATE_WAIT;
        end
      end
      S_RATE_WAIT: begin
        cmd_o.div_rate = 1'b1;
        if (div_done_i) begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd_o.div_rate = 1'b1;
        cmd_o.commit   = 1'b1;
        state_d        = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // a wait state always has the divider running or just finished
  `BRM_ASSERT(a_wait_has_div,
    (state_q == S_MOD_WAIT || state_q == S_RATE_WAIT) |-> (div_busy_i || div_done_i),
    clk_i, rst_ni, "divider idle while controller waits on it")
  // done only lands where the controller listens for it
  `BRM_ASSERT(a_done_expected,
    div_done_i |-> (state_q == S_MOD_WAIT || state_q == S_RATE_WAIT),
    clk_i, rst_ni, "divider result arrived in an unexpected state")
  // a new division never starts on top of a running one
  `BRM_ASSERT(a_start_idle_div, cmd_o.div_start |-> !div_busy_i,
    clk_i, rst_ni, "divider restarted while busy")
  // state is committed only while the window and gap checks still hold
  `BRM_ASSERT(a_commit_passed, cmd_o.commit |-> stat_i.pass,
    clk_i, rst_ni, "rate committed without passing the checks")
  `BRM_ASSERT_ALWAYS(a_busy_done_excl, !(div_busy_i && div_done_i),
    clk_i, "divider busy and done together")

endmodule

### design/bit_rate_meter_unit.sv
// ----------------------------------------------------------------------------
// bit_rate_meter_unit
// Throughput meter: accumulates bytes over a millisecond window, reports bps.
// ----------------------------------------------------------------------------
// Each input item carries a millisecond timestamp and a command (add bytes,
// preset rate, restart window); every item returns exactly one result holding
// the current rate in bits per second and a flag that is set when that item
// produced a new rate. One item is in work at a time. An item that does not
// recompute (preset, restart, unused code, add without calc_enable) goes from
// the apply state straight to the output state, and the input is ready again
// once the output register is free. A recompute runs the shared radix-2
// divider: first to round the timestamp down to a multiple of precision_ms
// (skipped when precision_ms is 1), then for the rounded quotient
// bytes*8000/window. A recompute whose window or gap check fails ends without
// a quotient or a commit; one that passes with too few bytes for a nonzero
// rate skips the quotient and commits a zero rate. The result sits in an
// output register, so a finished item waits there while the next one is
// accepted. Configuration (period_ms, average_mode, precision_ms at indexes
// 0..2) must be written only while idle; the block itself does not enforce
// this.
// ----------------------------------------------------------------------------
module bit_rate_meter_unit import brm_pkg::*; #(
  parameter int unsigned TimeWidth = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,
  brm_stream_if.sink            in_i,
  brm_stream_if.source          out_o
);
  // divider wide enough for a full timestamp and for bytes*16000 + window
  localparam int unsigned DivW  = (TimeWidth > NUMD_W) ? TimeWidth : NUMD_W;
  localparam int unsigned StepW = $clog2(DivW+1);

  brm_ctrl_t        ctrl;
  brm_stat_t        stat;
  in_item_t         in_item;
  out_item_t        out_item;
  logic             in_ready;
  logic             out_valid;

  // shared divider
  logic             div_busy;
  logic             div_done;
  logic [StepW-1:0] div_steps;
  logic [DivW-1:0]  div_dividend;
  logic [DivW-1:0]  div_divisor;
  logic [DivW-1:0]  div_quotient;
  logic [DivW-1:0]  div_remainder;

  assign in_item.cmd          = in_i.payload.cmd;
  assign in_item.now_ms       = in_i.payload.now_ms;
  assign in_item.byte_count   = in_i.payload.byte_count;
  assign in_item.calc_enable  = in_i.payload.calc_enable;
  assign in_item.preset_value = in_i.payload.preset_value;
  assign in_i.ready           = in_ready;

  assign out_o.valid                = out_valid;
  assign out_o.payload.rate_bps     = out_item.rate_bps;
  assign out_o.payload.updated      = out_item.updated;

  brm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .div_busy_i  (div_busy),
    .div_done_i  (div_done),
    .cmd_o       (ctrl)
  );

  brm_datapath #(
    .TimeWidth (TimeWidth),
    .DivW      (DivW)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .item_i          (in_item),
    .ctrl_i          (ctrl),
    .stat_o          (stat),
    .div_steps_o     (div_steps),
    .div_dividend_o  (div_dividend),
    .div_divisor_o   (div_divisor),
    .div_quotient_i  (div_quotient),
    .div_remainder_i (div_remainder),
    .out_item_o      (out_item)
  );

  brm_divider #(
    .Width (DivW)
  ) u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (ctrl.div_start),
    .steps_i     (div_steps),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .busy_o      (div_busy),
    .done_o      (div_done),
    .quotient_o  (div_quotient),
    .remainder_o (div_remainder)
  );

endmodule
